### hw/rtl/hrtp_pkg.sv
// Package for the HTTP request token parser: phase and token codes, characters,
// register indexes and reset values, and the records passed between the parts.
// Has no dependencies.
package hrtp_pkg;

  localparam int unsigned LIMIT_W = 12;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [2:0] PH_METHOD   = 3'd0;
  localparam logic [2:0] PH_URI      = 3'd1;
  localparam logic [2:0] PH_PROTOCOL = 3'd2;
  localparam logic [2:0] PH_NAME     = 3'd3;
  localparam logic [2:0] PH_VALUE    = 3'd4;
  localparam logic [2:0] PH_CLOSED   = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_CONNECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_METHOD_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_URI_LIMIT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LIMIT    = 3'd4;

  localparam logic [LIMIT_W-1:0] RST_METHOD_LIMIT   = 12'd15;
  localparam logic [LIMIT_W-1:0] RST_URI_LIMIT      = 12'd255;
  localparam logic [LIMIT_W-1:0] RST_PROTOCOL_LIMIT = 12'd15;
  localparam logic [LIMIT_W-1:0] RST_NAME_LIMIT     = 12'd63;
  localparam logic [LIMIT_W-1:0] RST_VALUE_LIMIT    = 12'd255;

  // One queued job: an optional late CR followed by an optional main result.
  typedef struct packed {
    logic             late;
    logic [LEN_W-1:0] late_len;
    logic             main;
    logic [2:0]       kind;
    logic [7:0]       ch;
    logic             cvalid;
    logic             done;
    logic [LEN_W-1:0] len;
    logic             closed;
  } hrtp_job_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       ch;
    logic             cvalid;
    logic             done;
    logic [LEN_W-1:0] len;
    logic             closed;
    logic             last;
  } hrtp_result_t;

endpackage

### hw/rtl/http_request_token_parser.sv
// Top level of the HTTP request token parser.
// Instantiates hrtp_front, hrtp_queue and hrtp_back; depends on hrtp_pkg.
//
// Takes one received byte per beat and reports each token character with its
// token kind and running length, and one done beat per terminator. A byte is
// accepted in every cycle in which the four-entry job queue has room; each job
// leaves the output register as one beat, or two when a held CR is released
// late, so the sustained rate is one byte per cycle while out_stall is low,
// except after a late CR, where the extra beat takes an output slot. Each
// accepted byte's job passes through the queue and then the output register.
module http_request_token_parser import hrtp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [7:0]           data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           token_kind,
  output logic [7:0]           token_char,
  output logic                 char_valid,
  output logic                 token_done,
  output logic [LEN_W-1:0]     token_length,
  output logic                 closed,
  output logic                 last_result
);

  logic         accept;
  logic         job_valid;
  hrtp_job_t    job;
  logic         queue_full;
  logic         pop;
  logic         head_valid;
  hrtp_job_t    head_job;
  hrtp_result_t result;

  assign cfg_ready = 1'b1;
  assign in_stall  = queue_full;
  assign accept    = in_valid && !queue_full;

  hrtp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .opcode    (opcode),
    .data_byte (data_byte),
    .job_valid (job_valid),
    .job       (job)
  );

  hrtp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_valid),
    .push_job   (job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  hrtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign token_kind   = result.kind;
  assign token_char   = result.ch;
  assign char_valid   = result.cvalid;
  assign token_done   = result.done;
  assign token_length = result.len;
  assign closed       = result.closed;
  assign last_result  = result.last;

endmodule

### hw/rtl/hrtp_front.sv
// Front part of the token parser: configuration registers, parse state and the
// classification of each received byte into a job. Depends on hrtp_pkg.
module hrtp_front import hrtp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  input  logic                 accept,
  input  logic                 opcode,
  input  logic [7:0]           data_byte,
  output logic                 job_valid,
  output hrtp_job_t            job
);

  localparam int unsigned CW = (LENGTH_BITS > LIMIT_W) ? LENGTH_BITS : LIMIT_W;
  localparam int unsigned XW = (CW > LEN_W) ? CW : LEN_W;

  logic [LIMIT_W-1:0] method_limit;
  logic [LIMIT_W-1:0] uri_limit;
  logic [LIMIT_W-1:0] protocol_limit;
  logic [LIMIT_W-1:0] header_name_limit;
  logic [LIMIT_W-1:0] header_value_limit;

  logic [2:0]             phase;
  logic [2:0]             phase_next;
  logic [LENGTH_BITS-1:0] count;
  logic [LENGTH_BITS-1:0] count_next;
  logic                   cr_pending;
  logic                   cr_pending_next;

  logic [LIMIT_W-1:0]     lim;
  logic [CW-1:0]          cnt_w;
  logic [CW-1:0]          lim_w;
  logic [LENGTH_BITS-1:0] count_inc;
  logic [LENGTH_BITS-1:0] count_dec;
  logic [XW-1:0]          len_cur;
  logic [XW-1:0]          len_inc;
  logic [XW-1:0]          len_dec;
  logic [7:0]             term;
  logic                   crphase;
  logic [2:0]             phase_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      method_limit       <= RST_METHOD_LIMIT;
      uri_limit          <= RST_URI_LIMIT;
      protocol_limit     <= RST_PROTOCOL_LIMIT;
      header_name_limit  <= RST_NAME_LIMIT;
      header_value_limit <= RST_VALUE_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_METHOD_LIMIT:   method_limit       <= cfg_data;
        REG_URI_LIMIT:      uri_limit          <= cfg_data;
        REG_PROTOCOL_LIMIT: protocol_limit     <= cfg_data;
        REG_NAME_LIMIT:     header_name_limit  <= cfg_data;
        REG_VALUE_LIMIT:    header_value_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase)
      PH_METHOD:   lim = method_limit;
      PH_URI:      lim = uri_limit;
      PH_PROTOCOL: lim = protocol_limit;
      PH_NAME:     lim = header_name_limit;
      default:     lim = header_value_limit;
    endcase
  end

  assign cnt_w     = CW'(count);
  assign lim_w     = CW'(lim);
  assign count_inc = count + 1'b1;
  assign count_dec = count - 1'b1;
  assign len_cur   = XW'(count);
  assign len_inc   = XW'(count_inc);
  assign len_dec   = XW'(count_dec);
  assign crphase   = (phase == PH_PROTOCOL) || (phase == PH_VALUE);
  assign term      = (phase == PH_METHOD || phase == PH_URI) ? CH_SPACE :
                     (phase == PH_NAME) ? CH_COLON : CH_LF;
  assign phase_adv = (phase == PH_VALUE) ? PH_NAME : phase + 3'd1;

  always_comb begin
    job             = '0;
    phase_next      = phase;
    count_next      = count;
    cr_pending_next = cr_pending;
    job.kind        = phase;
    if (opcode == OP_CONNECT) begin
      phase_next      = PH_METHOD;
      count_next      = '0;
      cr_pending_next = 1'b0;
    end else if (phase >= PH_CLOSED) begin
      job.main   = 1'b1;
      job.kind   = PH_METHOD;
      job.closed = 1'b1;
    end else if (cr_pending && data_byte == CH_LF) begin
      cr_pending_next = 1'b0;
      job.main        = 1'b1;
      job.done        = 1'b1;
      job.len         = len_dec[LEN_W-1:0];
      count_next      = '0;
      phase_next      = phase_adv;
    end else begin
      cr_pending_next = 1'b0;
      if (cr_pending) begin
        job.late     = 1'b1;
        job.late_len = len_cur[LEN_W-1:0];
      end
      if (data_byte == term) begin
        job.main   = 1'b1;
        job.done   = 1'b1;
        job.len    = len_cur[LEN_W-1:0];
        count_next = '0;
        phase_next = phase_adv;
      end else if (cnt_w >= lim_w || count == {LENGTH_BITS{1'b1}}) begin
        job.main   = 1'b1;
        job.closed = 1'b1;
        job.len    = len_cur[LEN_W-1:0];
        phase_next = PH_CLOSED;
      end else begin
        count_next = count_inc;
        if (crphase && data_byte == CH_CR) begin
          cr_pending_next = 1'b1;
        end else begin
          job.main   = 1'b1;
          job.ch     = data_byte;
          job.cvalid = 1'b1;
          job.len    = len_inc[LEN_W-1:0];
        end
      end
    end
  end

  assign job_valid = accept && (job.late || job.main);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_METHOD;
      count      <= '0;
      cr_pending <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      count      <= count_next;
      cr_pending <= cr_pending_next;
    end
  end

endmodule

### hw/rtl/hrtp_queue.sv
// Short job queue between the front and back parts of the token parser.
// Depends on hrtp_pkg for the job record.
module hrtp_queue import hrtp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  hrtp_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output hrtp_job_t head_job
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  hrtp_job_t       slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;

  assign full       = (fill == (PW+1)'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/hrtp_back.sv
// Back part of the token parser: expands each queued job into one or two
// result beats and holds them in the output register. Depends on hrtp_pkg.
module hrtp_back import hrtp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  hrtp_job_t    head_job,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output hrtp_result_t result
);

  logic         late_done;
  logic         advance;
  logic         emit_late;
  hrtp_result_t next_result;

  assign advance   = !out_valid || !out_stall;
  assign emit_late = head_job.late && !late_done;
  assign pop       = advance && head_valid && !(emit_late && head_job.main);

  always_comb begin
    if (emit_late) begin
      next_result.kind   = head_job.kind;
      next_result.ch     = CH_CR;
      next_result.cvalid = 1'b1;
      next_result.done   = 1'b0;
      next_result.len    = head_job.late_len;
      next_result.closed = 1'b0;
      next_result.last   = !head_job.main;
    end else begin
      next_result.kind   = head_job.kind;
      next_result.ch     = head_job.ch;
      next_result.cvalid = head_job.cvalid;
      next_result.done   = head_job.done;
      next_result.len    = head_job.len;
      next_result.closed = head_job.closed;
      next_result.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= next_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      late_done <= 1'b0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        late_done <= emit_late && head_job.main;
      end
    end
  end

endmodule
